### sv/plt_pkg.sv
// Shared types and constants for the positional list table.
`timescale 1ns / 1ps

package plt_pkg;

    localparam int unsigned VALUE_BITS  = 32;
    localparam int unsigned POS_BITS    = 6;
    localparam int unsigned CAP_BITS    = 7;
    localparam int unsigned LEN_BITS    = 7;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;
    // Cells folded into one registered read group.
    localparam int unsigned RD_GROUP    = 8;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_GET    = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2
    } cell_op_t;

    typedef struct packed {
        action_t                 action;
        logic [POS_BITS-1:0]     position;
        logic [VALUE_BITS-1:0]   value;
    } plt_in_t;

    typedef struct packed {
        logic                    ok;
        logic [VALUE_BITS-1:0]   value_out;
        logic [LEN_BITS-1:0]     list_length;
    } plt_out_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        cell_op_t op;
        logic     rd_en;
    } cell_cmd_t;

endpackage

### sv/plt_cell.sv
// One storage cell of the list row: holds an entry and trades it with its neighbours.
`timescale 1ns / 1ps

module plt_cell
    import plt_pkg::*;
#(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned IW        = 6,
    parameter int unsigned IDX       = 0
) (
    input  logic                 aclk,
    input  cell_cmd_t            cmd,
    input  logic [IW-1:0]        op_idx,
    input  logic [IW-1:0]        rd_idx,
    input  logic [WORD_BITS-1:0] load_word,
    input  logic [WORD_BITS-1:0] left_data,
    input  logic [WORD_BITS-1:0] right_data,
    output logic [WORD_BITS-1:0] data_out,
    output logic [WORD_BITS-1:0] rd_data
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        unique case (cmd.op)
            OP_INS: begin
                if (MY_IDX == op_idx) begin
                    data_next = load_word;
                end else if (MY_IDX > op_idx) begin
                    data_next = left_data;
                end
            end
            OP_DEL: begin
                // close the gap: take the entry above
                if (MY_IDX >= op_idx) begin
                    data_next = right_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign rd_data  = (cmd.rd_en && (rd_idx == MY_IDX)) ? data_reg : '0;

endmodule

### sv/positional_list_table_core.sv
// Top level of the positional list table: control, row of cells and read pipeline.
`timescale 1ns / 1ps
// An accepted input is registered in read stage 1, then in the output register.
// Throughput: one item per cycle unless m_ready stalls; every cell shifts in the
// accept cycle, the addressed entry's read passes one registered OR group stage.
// Reset (aresetn low, synchronous): list length 0, capacity 64, pipeline empty;
// entry contents are not cleared and are only read once written.
module positional_list_table_core
    import plt_pkg::*;
#(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  plt_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output plt_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAP_BITS-1:0]  cfg_data
);

    localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CW    = ((CNT_W > CAP_BITS) ? CNT_W : CAP_BITS) + 1;
    localparam int unsigned NGRP  = (DEPTH + RD_GROUP - 1) / RD_GROUP;

    // ---------------- configuration ----------------
    logic [CAP_BITS-1:0] cap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    // ---------------- handshake ----------------
    logic p1_vld_reg, p1_vld_next;
    logic out_vld_reg, out_vld_next;
    logic adv1;
    logic s_acc;

    assign adv1    = p1_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !p1_vld_reg || adv1;
    assign s_acc   = s_valid && s_ready;

    // ---------------- decode ----------------
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CW-1:0]    cap_ext, cap_eff, cnt_ext, pos_ext, cnt_new;
    logic             ins_ok, rd_ok, ok_dec;
    cell_cmd_t        cmd;
    logic [IW-1:0]    op_idx, rd_idx;
    logic [WORD_BITS-1:0] word_in;

    generate
        if (WORD_BITS <= VALUE_BITS) begin : g_word_narrow
            assign word_in = s_data.value[WORD_BITS-1:0];
        end else begin : g_word_wide
            assign word_in = {{(WORD_BITS - VALUE_BITS){1'b0}}, s_data.value};
        end
    endgenerate

    always_comb begin
        cap_ext = CW'(cap_reg);
        cap_eff = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
        cnt_ext = CW'(count_reg);
        pos_ext = CW'(s_data.position);
        ins_ok  = (pos_ext < cap_eff) && ((cnt_ext + CW'(1)) <= cap_eff);
        rd_ok   = pos_ext < cnt_ext;
        rd_idx  = pos_ext[IW-1:0];
        op_idx  = pos_ext[IW-1:0];
        cmd     = '{op: OP_HOLD, rd_en: 1'b0};
        ok_dec  = 1'b0;
        cnt_new = cnt_ext;
        unique case (s_data.action)
            ACT_INSERT: begin
                ok_dec = ins_ok;
                // a position at or past the end appends
                if (pos_ext >= cnt_ext) begin
                    op_idx = cnt_ext[IW-1:0];
                end
                if (ins_ok) begin
                    cmd.op  = OP_INS;
                    cnt_new = cnt_ext + CW'(1);
                end
            end
            ACT_GET: begin
                ok_dec    = rd_ok;
                cmd.rd_en = rd_ok;
            end
            ACT_DELETE: begin
                ok_dec    = rd_ok;
                cmd.rd_en = rd_ok;
                if (rd_ok) begin
                    cmd.op  = OP_DEL;
                    cnt_new = cnt_ext - CW'(1);
                end
            end
            ACT_CLEAR: begin
                ok_dec  = 1'b1;
                cnt_new = '0;
            end
            default: ok_dec = 1'b0;
        endcase
        if (!s_acc) begin
            cmd = '{op: OP_HOLD, rd_en: 1'b0};
        end
        count_next = s_acc ? cnt_new[CNT_W-1:0] : count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // ---------------- row of cells ----------------
    logic [WORD_BITS-1:0] cell_data [DEPTH];
    logic [WORD_BITS-1:0] cell_rd   [DEPTH];

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic [WORD_BITS-1:0] left_w, right_w;
            if (i == 0) begin : g_first
                assign left_w = '0;
            end else begin : g_mid_l
                assign left_w = cell_data[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign right_w = cell_data[i];
            end else begin : g_mid_r
                assign right_w = cell_data[i+1];
            end
            plt_cell #(
                .WORD_BITS (WORD_BITS),
                .IW        (IW),
                .IDX       (i)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .op_idx     (op_idx),
                .rd_idx     (rd_idx),
                .load_word  (word_in),
                .left_data  (left_w),
                .right_data (right_w),
                .data_out   (cell_data[i]),
                .rd_data    (cell_rd[i])
            );
        end
    endgenerate

    // ---------------- read stage 1: grouped OR ----------------
    logic [WORD_BITS-1:0] grp_reg  [NGRP];
    logic [WORD_BITS-1:0] grp_next [NGRP];
    logic                 p1_ok_reg;
    logic [LEN_BITS-1:0]  p1_len_reg;

    generate
        for (genvar g = 0; g < NGRP; g++) begin : g_grp
            always_comb begin
                grp_next[g] = '0;
                for (int k = 0; k < RD_GROUP; k++) begin
                    if (g * RD_GROUP + k < DEPTH) begin
                        grp_next[g] = grp_next[g] | cell_rd[g * RD_GROUP + k];
                    end
                end
            end
        end
    endgenerate

    assign p1_vld_next = s_acc ? 1'b1 : (adv1 ? 1'b0 : p1_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= p1_vld_next;
        end
    end

    // capture the addressed entry before the row shifts at the same edge
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            grp_reg    <= grp_next;
            p1_ok_reg  <= ok_dec;
            p1_len_reg <= cnt_new[LEN_BITS-1:0];
        end
    end

    // ---------------- read stage 2: output register ----------------
    logic [WORD_BITS-1:0]  rd_word;
    logic [VALUE_BITS-1:0] rd_value;
    plt_out_t              out_reg;

    always_comb begin
        rd_word = '0;
        for (int g = 0; g < NGRP; g++) begin
            rd_word = rd_word | grp_reg[g];
        end
    end

    generate
        if (WORD_BITS >= VALUE_BITS) begin : g_out_wide
            assign rd_value = rd_word[VALUE_BITS-1:0];
        end else begin : g_out_narrow
            assign rd_value = {{(VALUE_BITS - WORD_BITS){1'b0}}, rd_word};
        end
    endgenerate

    assign out_vld_next = adv1 ? 1'b1 : ((out_vld_reg && m_ready) ? 1'b0 : out_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            out_reg.ok          <= p1_ok_reg;
            out_reg.value_out   <= rd_value;
            out_reg.list_length <= p1_len_reg;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule
